### rtl/core/swpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swpd_pkg
// Shared types and constants of the sync word packet deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package swpd_pkg;

  localparam int unsigned SYNC_BYTES_DEF   = 8;
  localparam int unsigned HEADER_BYTES_DEF = 16;

  localparam logic [63:0] SYNC_WORD_RESET = 64'h2211_9988_7766_5544;
  localparam int unsigned LEN_LO_POS      = 8;
  localparam int unsigned LEN_HI_POS      = 9;
  localparam int unsigned MASKED_BYTES    = 6;
  localparam logic [7:0]  FILL_BYTE       = 8'hFF;
  localparam logic [15:0] LOST_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       block_end;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_end;
    logic [15:0] lost_blocks;
  } res_item_t;

endpackage

`default_nettype wire

### rtl/core/swpd_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swpd_in_stage
// Input register: holds one received item until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module swpd_in_stage
  import swpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rx_item_t in_item,
  input  wire logic     take,
  output logic          hold_valid,
  output rx_item_t      hold_item
);

  logic     valid_r, valid_nxt;
  rx_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/swpd_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swpd_core
// Deframer state: sync hunt window, header parse, payload count, lost count.
// ---------------------------------------------------------------------------
`default_nettype none

module swpd_core
  import swpd_pkg::*;
#(
  parameter int unsigned SYNC_BYTES   = SYNC_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_sync_word,
  input  wire logic        fire,
  input  wire rx_item_t    item,
  output logic             emits,
  output res_item_t        res
);

  localparam int unsigned WIN_W  = 8 * SYNC_BYTES;
  localparam int unsigned FILL_W = $clog2(SYNC_BYTES + 1);
  localparam int unsigned HPOS_W = $clog2(HEADER_BYTES);

  logic [63:0]       sync_word_r;
  phase_t            phase_r, phase_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt, win_shift;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [HPOS_W-1:0] hpos_r, hpos_nxt;
  logic [15:0]       len_r, len_nxt, len_upd;
  logic [15:0]       cnt_r, cnt_nxt;
  logic [15:0]       lost_r, lost_nxt;
  logic              match, hdr_last, pay_last;

  assign win_shift = {item.rx_byte, win_r[WIN_W-1:8]};
  assign fill_inc  = (fill_r < FILL_W'(SYNC_BYTES)) ? fill_r + 1'b1 : fill_r;
  assign match     = (fill_inc == FILL_W'(SYNC_BYTES)) && (win_shift == sync_word_r[WIN_W-1:0]);
  assign hdr_last  = (hpos_r >= HPOS_W'(HEADER_BYTES - 1));
  assign pay_last  = ({1'b0, cnt_r} + 17'd1) >= {1'b0, len_r};

  always_comb begin
    len_upd = len_r;
    if (hpos_r == HPOS_W'(LEN_LO_POS)) begin
      len_upd = {len_r[15:8], item.rx_byte};
    end else if (hpos_r == HPOS_W'(LEN_HI_POS)) begin
      len_upd = {item.rx_byte, len_r[7:0]};
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_last) begin
            phase_nxt = (len_upd == 16'd0) ? PH_HUNT : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = match ? PH_HEADER : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    hpos_nxt = hpos_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    lost_nxt = lost_r;
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          len_nxt = len_upd;
          if (hdr_last) begin
            cnt_nxt = '0;
            if (len_upd == 16'd0) begin
              win_nxt  = '0;
              fill_nxt = '0;
              hpos_nxt = '0;
            end
          end else begin
            hpos_nxt = hpos_r + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            win_nxt  = '0;
            fill_nxt = '0;
            hpos_nxt = '0;
            len_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            cnt_nxt = cnt_r + 16'd1;
          end
        end
        default: begin
          win_nxt  = win_shift;
          fill_nxt = fill_inc;
          if (match) begin
            hpos_nxt = HPOS_W'(SYNC_BYTES);
            len_nxt  = '0;
            win_nxt  = '0;
            fill_nxt = '0;
          end else if (item.block_end && (lost_r != LOST_MAX)) begin
            lost_nxt = lost_r + 16'd1;
          end
        end
      endcase
    end
  end

  assign emits           = (phase_r == PH_PAYLOAD);
  assign res.out_byte    = (cnt_r < 16'(MASKED_BYTES)) ? FILL_BYTE : item.rx_byte;
  assign res.packet_end  = pay_last;
  assign res.lost_blocks = lost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_WORD_RESET;
      phase_r     <= PH_HUNT;
      win_r       <= '0;
      fill_r      <= '0;
      hpos_r      <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      lost_r      <= '0;
    end else begin
      if (cfg_we) begin
        sync_word_r <= cfg_sync_word;
      end
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      hpos_r  <= hpos_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      lost_r  <= lost_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SYNC_BYTES))
    else $error("hunt window fill beyond sync length");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> ((len_r != 16'd0) && (cnt_r < len_r)))
    else $error("payload phase with count outside packet length");

  a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (hpos_r >= HPOS_W'(SYNC_BYTES)))
    else $error("header position before end of sync word");

  a_lost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (lost_r >= $past(lost_r)))
    else $error("lost block count went down");

  a_lost_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire || (phase_r != PH_HUNT)) |=> $stable(lost_r))
    else $error("lost block count moved outside hunt");
`endif

endmodule

`default_nettype wire

### rtl/core/swpd_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swpd_out_stage
// Result register: holds one payload item until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module swpd_out_stage
  import swpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire res_item_t res,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_ready,
  output res_item_t      out_item
);

  logic      valid_r, valid_nxt;
  res_item_t item_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item_r <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sync_word_packet_deframer.sv
`timescale 1ns / 1ps
// A payload item accepted on the in_ channel passes the input register, then the result
//   register, before it is on the out_ channel.
// Throughput: one item per cycle; only a stalled result register slows the input.
// Reset (rst_n low at a clock edge): hunt restarts with an empty window, the lost
//   block count clears and the sync word returns to its default value.
// ---------------------------------------------------------------------------
// sync_word_packet_deframer
// Hunts for a sync word, reads the header length and emits the payload bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_word_packet_deframer
  import swpd_pkg::*;
#(
  parameter int unsigned SYNC_BYTES   = SYNC_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_sync_word,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_block_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_packet_end,
  output logic [15:0]      out_lost_blocks
);

  rx_item_t  in_item, hold_item;
  res_item_t res, out_item;
  logic      hold_valid, fire, emits, free;

  assign in_item.rx_byte   = in_rx_byte;
  assign in_item.block_end = in_block_end;

  // advance when the result slot can take the item, or the item makes none
  assign fire = hold_valid && (!emits || free);

  swpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  swpd_core #(
    .SYNC_BYTES   (SYNC_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_sync_word (cfg_sync_word),
    .fire          (fire),
    .item          (hold_item),
    .emits         (emits),
    .res           (res)
  );

  swpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && emits),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_byte        = out_item.out_byte;
  assign out_packet_end  = out_item.packet_end;
  assign out_lost_blocks = out_item.lost_blocks;

endmodule

`default_nettype wire
